// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the filter core. Both expect signals
// named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// Scalar Kalman filter package
// Default widths, register reset values and register index codes.
// ----------------------------------------------------------------------------
package skf_pkg;

	// Default fixed-point format: Q15.16 data, Q1.16 gain.
	localparam int FRAC_BITS_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Register reset values.
	localparam longint unsigned Q_RESET    = 655;
	localparam longint unsigned R_RESET    = 6554;
	localparam longint unsigned INIT_RESET = 0;

	// Register index codes, taken from the word address.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_Q    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_R    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_INIT = 2'd2;

endpackage

// ----- rtl/skf_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding Q, R and the starting estimate. Any write
// to a known register also restarts the filter state.
// ----------------------------------------------------------------------------
module skf_cfg #(
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
	parameter int PDATA_W    = 32,
	parameter int ADDR_LSB   = 2,
	localparam int PADDR_W   = ADDR_LSB + skf_pkg::REG_IDX_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic [DATA_WIDTH-1:0] process_noise,
	output logic [DATA_WIDTH-1:0] measurement_noise,
	output logic [DATA_WIDTH-1:0] init_next,
	output logic                  restart
);
	import skf_pkg::*;

	logic [REG_IDX_W-1:0]  idx;
	logic                  wr;
	logic [DATA_WIDTH-1:0] q_q;
	logic [DATA_WIDTH-1:0] r_q;
	logic [DATA_WIDTH-1:0] init_q;

	// Word decode; the low byte-offset bits are ignored.
	assign idx = paddr[PADDR_W-1:ADDR_LSB];
	assign wr  = psel & penable & pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q    <= DATA_WIDTH'(Q_RESET);
			r_q    <= DATA_WIDTH'(R_RESET);
			init_q <= DATA_WIDTH'(INIT_RESET);
		end else if (wr) begin
			unique case (idx)
				REG_Q:    q_q    <= pwdata[DATA_WIDTH-1:0];
				REG_R:    r_q    <= pwdata[DATA_WIDTH-1:0];
				REG_INIT: init_q <= pwdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (idx)
			REG_Q:    prdata = PDATA_W'(q_q);
			REG_R:    prdata = PDATA_W'(r_q);
			REG_INIT: prdata = PDATA_W'(init_q);
			default:  prdata = '0;
		endcase
	end

	// A write to a known register reloads the estimate and the covariance.
	// The new starting value is forwarded so the reload sees it at once.
	assign restart = wr & ((idx == REG_Q) || (idx == REG_R) || (idx == REG_INIT));
	assign init_next = (wr && (idx == REG_INIT)) ? pwdata[DATA_WIDTH-1:0] : init_q;
	assign process_noise     = q_q;
	assign measurement_noise = r_q;

endmodule

// ----- rtl/skf_addsub.sv -----
// ----------------------------------------------------------------------------
// Shared adder
// The single add/subtract unit reused by every step of the filter update.
// The carry out doubles as the unsigned "a >= b" flag when subtracting.
// ----------------------------------------------------------------------------
module skf_addsub #(
	parameter int W = 34
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic         sub,
	output logic [W-1:0] sum,
	output logic         carry
);
	logic [W:0] full;

	// Subtraction is a plus the inverted b plus one.
	assign full  = {1'b0, a} + {1'b0, b ^ {W{sub}}} + (W+1)'(sub);
	assign sum   = full[W-1:0];
	assign carry = full[W];

endmodule

// ----- rtl/skf_core.sv -----
// ----------------------------------------------------------------------------
// Filter sequencer and datapath
// Steps one measurement through predict, gain division, correction and
// covariance scaling, all on the shared adder, and holds the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skf_core #(
	parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] sample,
	input  logic [DATA_WIDTH-1:0] process_noise,
	input  logic [DATA_WIDTH-1:0] measurement_noise,
	input  logic [DATA_WIDTH-1:0] init_next,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] estimate,
	output logic [FRAC_BITS:0]    gain,
	output logic [DATA_WIDTH-1:0] covariance
);
	import skf_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int GW = FRAC_BITS + 1;
	localparam int MW = DATA_WIDTH + 1;
	localparam int AW = ((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS) + 2;
	localparam int CW = $clog2(GW + 1);
	localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [DW-1:0] COV_ONE  = (FRAC_BITS >= DATA_WIDTH) ?
		{DW{1'b1}} : (DW'(1) << FRAC_BITS);

	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_PRED = 11'b000_0000_0010,
		S_DEN  = 11'b000_0000_0100,
		S_DIV  = 11'b000_0000_1000,
		S_DIFF = 11'b000_0001_0000,
		S_ABS  = 11'b000_0010_0000,
		S_MUL1 = 11'b000_0100_0000,
		S_EST  = 11'b000_1000_0000,
		S_CGN  = 11'b001_0000_0000,
		S_MUL2 = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic [DW-1:0]  est_q;
	logic [DW-1:0]  cov_st_q;
	logic [DW-1:0]  z_q;
	logic [DW-1:0]  p_q;
	logic [MW-1:0]  den_q;
	logic [AW-1:0]  rem_q;
	logic [GW-1:0]  gain_q;
	logic           neg_q;
	logic [MW-1:0]  mcand_q;
	logic [MW-1:0]  hi_q;
	logic [GW-1:0]  lo_q;
	logic           out_valid_q;
	logic [DW-1:0]  out_est_q;
	logic [GW-1:0]  out_gain_q;
	logic [DW-1:0]  out_cov_q;

	logic [AW-1:0]       op_a;
	logic [AW-1:0]       op_b;
	logic                op_sub;
	logic [AW-1:0]       sum;
	logic                carry;
	logic [MW+GW-1:0]    prod;
	logic [MW-1:0]       corr;
	logic                load_out;

	// Product of the serial multiplier and its two scaled views.
	assign prod = {hi_q, lo_q};
	assign corr = prod[FRAC_BITS +: MW];
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Operand selection for the shared adder.
	always_comb begin
		op_a   = '0;
		op_b   = '0;
		op_sub = 1'b0;
		unique case (state_q) inside
			S_PRED: begin
				op_a = AW'(cov_st_q);
				op_b = AW'(process_noise);
			end
			S_DEN: begin
				op_a = AW'(p_q);
				op_b = AW'(measurement_noise);
			end
			S_DIV: begin
				op_a   = rem_q << 1;
				op_b   = AW'(den_q);
				op_sub = 1'b1;
			end
			S_DIFF: begin
				op_a   = {{(AW-DW){z_q[DW-1]}}, z_q};
				op_b   = {{(AW-DW){est_q[DW-1]}}, est_q};
				op_sub = 1'b1;
			end
			S_ABS: begin
				op_b   = {{(AW-MW){mcand_q[MW-1]}}, mcand_q};
				op_sub = 1'b1;
			end
			S_MUL1, S_MUL2: begin
				op_a = AW'(hi_q);
				op_b = lo_q[0] ? AW'(mcand_q) : '0;
			end
			S_EST: begin
				op_a   = {{(AW-DW){est_q[DW-1]}}, est_q};
				op_b   = AW'(corr);
				op_sub = neg_q;
			end
			S_CGN: begin
				op_a   = AW'(GAIN_ONE);
				op_b   = AW'(gain_q);
				op_sub = 1'b1;
			end
			default: ;
		endcase
	end

	skf_addsub #(
		.W(AW)
	) u_addsub (
		.a     (op_a),
		.b     (op_b),
		.sub   (op_sub),
		.sum   (sum),
		.carry (carry)
	);

	// Sequencer, filter state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			est_q       <= DW'(INIT_RESET);
			cov_st_q    <= COV_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PRED;
					end
				end
				S_PRED: state_q <= S_DEN;
				S_DEN: begin
					cnt_q   <= CW'(FRAC_BITS);
					state_q <= (measurement_noise == '0) ? S_DIFF : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: state_q <= S_ABS;
				S_ABS: begin
					cnt_q   <= CW'(GW);
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_EST;
					end
				end
				S_EST: begin
					est_q   <= sum[DW-1:0];
					state_q <= S_CGN;
				end
				S_CGN: begin
					cnt_q   <= CW'(GW);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						cov_st_q    <= prod[FRAC_BITS +: DW];
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A register write reloads the state; the user must write only while idle, the block does not enforce it.
			if (restart) begin
				est_q    <= init_next;
				cov_st_q <= COV_ONE;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid) begin
					z_q <= sample;
				end
			end
			S_PRED: begin
				// Saturate P + Q at the largest covariance.
				p_q <= sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
			end
			S_DEN: begin
				den_q  <= sum[MW-1:0];
				rem_q  <= AW'(p_q);
				if (measurement_noise == '0) begin
					gain_q <= (p_q != '0) ? GAIN_ONE : '0;
				end else begin
					gain_q <= '0;
				end
			end
			S_DIV: begin
				// One restoring-division step per cycle.
				gain_q <= {gain_q[GW-2:0], carry};
				rem_q  <= carry ? sum : (rem_q << 1);
			end
			S_DIFF: mcand_q <= sum[MW-1:0];
			S_ABS: begin
				neg_q <= mcand_q[MW-1];
				if (mcand_q[MW-1]) begin
					mcand_q <= sum[MW-1:0];
				end
				hi_q <= '0;
				lo_q <= gain_q;
			end
			S_MUL1, S_MUL2: begin
				// Shift-add multiply, multiplier bits taken from the low end.
				hi_q <= sum[MW:1];
				lo_q <= {sum[0], lo_q[GW-1:1]};
			end
			S_CGN: begin
				lo_q    <= sum[GW-1:0];
				hi_q    <= '0;
				mcand_q <= MW'(p_q);
			end
			S_FIN: begin
				if (load_out) begin
					out_est_q  <= est_q;
					out_gain_q <= gain_q;
					out_cov_q  <= prod[FRAC_BITS +: DW];
				end
			end
			default: ;
		endcase
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign estimate   = out_est_q;
	assign gain       = out_gain_q;
	assign covariance = out_cov_q;

	`ASSERT_CLK(a_accept_starts, (in_valid && in_ready) |=> (state_q == S_PRED))
	`ASSERT_NEVER(a_gain_range, (state_q == S_FIN) && (gain_q > GAIN_ONE))
	`ASSERT_CLK(a_hold_result, (state_q == S_FIN && out_valid_q && !out_ready) |=> (state_q == S_FIN))
	`ASSERT_CLK(a_div_count, (state_q == S_DIV) |-> (cnt_q != '0 && cnt_q <= CW'(FRAC_BITS)))

endmodule

// ----- rtl/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// Scalar Kalman filter
// Constant-state one-dimensional Kalman filter in fixed point. Each sample
// yields the new estimate, the gain used and the updated covariance.
//
//   Port group   Dir   Word contents
//   s_axis_*     in    sample (signed, DATA_WIDTH bits)
//   m_axis_*     out   estimate, gain (FRAC_BITS+1 bits), covariance
//   APB          in    process noise Q, measurement noise R, initial estimate
//
// Each sample passes through the serial divider, skipped when R is zero,
// and the two serial multiplies on the single shared adder. s_axis_tready
// is low while a sample is being worked on.
// A finished word waits in the output register while m_axis_tready is low;
// the next sample is taken meanwhile, and it stalls at its end until the
// register frees. Reset and any register write reload the estimate from
// the initial estimate register and set the covariance to 1.0.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
	parameter int FRAC_BITS  = skf_pkg::FRAC_BITS_DEF,
	parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEF,
	localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W     = ((2 * DATA_WIDTH + FRAC_BITS + 1 + 7) / 8) * 8,
	localparam int PDATA_W   = (DATA_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_LSB  = (DATA_WIDTH > 32) ? 3 : 2,
	localparam int PADDR_W   = ADDR_LSB + skf_pkg::REG_IDX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [IN_W-1:0]    s_axis_tdata,   // sample
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [OUT_W-1:0]   m_axis_tdata,   // estimate, gain, covariance
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	import skf_pkg::*;

	logic [DATA_WIDTH-1:0] q_cfg;
	logic [DATA_WIDTH-1:0] r_cfg;
	logic [DATA_WIDTH-1:0] init_next;
	logic                  restart;
	logic [DATA_WIDTH-1:0] estimate;
	logic [FRAC_BITS:0]    gain;
	logic [DATA_WIDTH-1:0] covariance;

	assign pready = 1'b1;

	// Register file.
	skf_cfg #(
		.DATA_WIDTH (DATA_WIDTH),
		.PDATA_W    (PDATA_W),
		.ADDR_LSB   (ADDR_LSB)
	) u_cfg (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.process_noise     (q_cfg),
		.measurement_noise (r_cfg),
		.init_next         (init_next),
		.restart           (restart)
	);

	// Filter engine.
	skf_core #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (s_axis_tvalid),
		.in_ready          (s_axis_tready),
		.sample            (s_axis_tdata[DATA_WIDTH-1:0]),
		.process_noise     (q_cfg),
		.measurement_noise (r_cfg),
		.init_next         (init_next),
		.restart           (restart),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.estimate          (estimate),
		.gain              (gain),
		.covariance        (covariance)
	);

	// Result word, estimate in the low bits, padded with zeros to bytes.
	assign m_axis_tdata = OUT_W'({covariance, gain, estimate});

endmodule
